// File: hdl/assert_macros.svh
// Assertion macros used by the allocator sequencer, ffha_ctrl.
// Clocked on clk_i; the reset-qualified form is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FFHA_ASSERT(lbl, prop, msg)
`define FFHA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: hdl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies; used by every allocator module.
package ffha_pkg;

  localparam int unsigned ARENA_BYTES_DEF  = 65536;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned WORD_BYTES_DEF   = 8;

  localparam int unsigned LIMIT_W   = 17;
  localparam int unsigned REQ_W     = 16;
  localparam int unsigned PAY_W     = 16;
  localparam int unsigned PADDR_W   = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } alloc_status_e;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] request_bytes;
    logic [REQ_W-1:0] release_offset;
  } item_t;

  typedef struct packed {
    logic [PAY_W-1:0] payload_offset;
    logic [1:0]       status;
  } result_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_START,
    CMD_READ_A,
    CMD_STEP_A,
    CMD_HIT,
    CMD_APPEND,
    CMD_WR_B,
    CMD_B_SET,
    CMD_B_ADV,
    CMD_READ_B,
    CMD_LINK_B,
    CMD_FREE_MARK,
    CMD_MERGE_A,
    CMD_KILL_B,
    CMD_A_PREV
  } dp_cmd_e;

  typedef struct packed {
    logic clr_done;
    logic a_reach;
    logic a_valid;
    logic a_used;
    logic a_fit;
    logic a_split;
    logic b_reach;
    logic b_valid;
    logic b_used;
    logic oom;
    logic free_bad;
    logic save_hp;
  } dp_status_t;

endpackage

// File: hdl/ffha_dp.sv
// Datapath of the allocator: header memory, block cursors and heap bookkeeping.
// Depends on ffha_pkg; driven by commands from ffha_ctrl.
module ffha_dp #(
  parameter int unsigned ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned WORD_BYTES   = ffha_pkg::WORD_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffha_pkg::dp_cmd_e             cmd_i,
  input  ffha_pkg::item_t               item_i,
  input  logic [ffha_pkg::LIMIT_W-1:0]  limit_i,
  output ffha_pkg::dp_status_t          status_o,
  output logic [ffha_pkg::PAY_W-1:0]    payload_o
);
  import ffha_pkg::*;

  localparam int unsigned SLOTS  = ARENA_BYTES / WORD_BYTES;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned WSH    = $clog2(WORD_BYTES);
  localparam int unsigned AW     = (($clog2(ARENA_BYTES) > 17) ? $clog2(ARENA_BYTES) : 17) + 2;
  localparam logic [AW-1:0]     ARENA_A   = AW'(ARENA_BYTES);
  localparam logic [AW-1:0]     HDR_A     = AW'(HEADER_BYTES);
  localparam logic [AW-1:0]     WORD_A    = AW'(WORD_BYTES);
  localparam logic [AW-1:0]     WMASK     = AW'(WORD_BYTES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef struct packed {
    logic              valid;
    logic              used;
    logic              has_prev;
    logic [AW-1:0]     size;
    logic [SLOT_W-1:0] prev;
  } hdr_t;

  hdr_t mem [SLOTS];

  logic [AW-1:0]     a_off_q, b_off_q, need_q, used_q;
  hdr_t              a_ent_q, b_ent_q;
  logic              fbad_q, head_q, sv_hp_q;
  logic [SLOT_W-1:0] tail_q, clr_q, link_q, sv_prev_q;
  logic [PAY_W-1:0]  pay_q;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [AW-1:0] off);
    logic [SLOT_W-1:0] r;
    if (off >= ARENA_A) begin
      r = LAST_SLOT;
    end else begin
      r = SLOT_W'(off >> WSH);
    end
    return r;
  endfunction

  logic [AW-1:0]     tail_off, lim_a, need_in, n_in, rel_a, a_next, b_next, nb_off;
  logic [SLOT_W-1:0] a_slot, b_slot, ns_slot;
  logic              fbad_in, a_split;
  hdr_t              hit_ent, new_ent, app_ent, link_ent, free_ent, merge_ent, kill_ent;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  hdr_t              mem_wdata;

  always_comb begin
    tail_off = AW'(tail_q) << WSH;
    lim_a    = (AW'(limit_i) > ARENA_A) ? ARENA_A : AW'(limit_i);
    n_in     = (item_i.request_bytes == '0) ? AW'(1) : AW'(item_i.request_bytes);
    need_in  = (n_in + WORD_A - AW'(1)) & ~WMASK;
    rel_a    = AW'(item_i.release_offset);
    fbad_in  = (rel_a < HDR_A) || (((rel_a - HDR_A) & WMASK) != '0);
    a_slot   = slot_of(a_off_q);
    b_slot   = slot_of(b_off_q);
    a_next   = a_off_q + HDR_A + a_ent_q.size;
    b_next   = b_off_q + HDR_A + b_ent_q.size;
    nb_off   = a_off_q + HDR_A + need_q;
    ns_slot  = slot_of(nb_off);
    a_split  = (a_ent_q.size - need_q) > (HDR_A + AW'(1));

    hit_ent      = a_ent_q;
    hit_ent.used = 1'b1;
    if (a_split) begin
      hit_ent.size = need_q;
    end
    new_ent = '{valid: 1'b1, used: 1'b0, has_prev: 1'b1,
                size: a_ent_q.size - need_q - HDR_A, prev: a_slot};
    app_ent = '{valid: 1'b1, used: 1'b1, has_prev: head_q, size: need_q, prev: tail_q};
    link_ent          = b_ent_q;
    link_ent.prev     = link_q;
    link_ent.has_prev = 1'b1;
    free_ent      = a_ent_q;
    free_ent.used = 1'b0;
    merge_ent      = a_ent_q;
    merge_ent.size = a_ent_q.size + HDR_A + b_ent_q.size;
    kill_ent       = b_ent_q;
    kill_ent.valid = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = a_slot;
    mem_wdata = hit_ent;
    case (cmd_i)
      CMD_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      CMD_HIT: begin
        mem_we = 1'b1;
      end
      CMD_APPEND: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(used_q);
        mem_wdata = app_ent;
      end
      CMD_WR_B: begin
        mem_we    = 1'b1;
        mem_waddr = b_slot;
        mem_wdata = b_ent_q;
      end
      CMD_LINK_B: begin
        mem_we    = 1'b1;
        mem_waddr = b_slot;
        mem_wdata = link_ent;
      end
      CMD_FREE_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = free_ent;
      end
      CMD_MERGE_A: begin
        mem_we    = 1'b1;
        mem_wdata = merge_ent;
      end
      CMD_KILL_B: begin
        mem_we    = 1'b1;
        mem_waddr = b_slot;
        mem_wdata = kill_ent;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    case (cmd_i)
      CMD_START: begin
        a_off_q <= (item_i.op == OP_FREE) ? (rel_a - HDR_A) : '0;
        need_q  <= need_in;
        fbad_q  <= fbad_in;
        pay_q   <= '0;
      end
      CMD_READ_A: begin
        a_ent_q <= mem[a_slot];
      end
      CMD_STEP_A: begin
        a_off_q <= a_next;
      end
      CMD_HIT: begin
        a_ent_q <= hit_ent;
        b_ent_q <= new_ent;
        b_off_q <= nb_off;
        link_q  <= ns_slot;
        pay_q   <= PAY_W'(a_off_q + HDR_A);
      end
      CMD_APPEND: begin
        pay_q <= PAY_W'(used_q + HDR_A);
      end
      CMD_B_SET: begin
        b_off_q <= a_next;
      end
      CMD_B_ADV: begin
        b_off_q <= b_next;
      end
      CMD_READ_B: begin
        b_ent_q <= mem[b_slot];
      end
      CMD_FREE_MARK: begin
        a_ent_q   <= free_ent;
        sv_prev_q <= a_ent_q.prev;
        sv_hp_q   <= a_ent_q.has_prev;
      end
      CMD_MERGE_A: begin
        a_ent_q <= merge_ent;
        link_q  <= a_slot;
      end
      CMD_A_PREV: begin
        a_off_q <= AW'(sv_prev_q) << WSH;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      used_q <= '0;
      tail_q <= '0;
      head_q <= 1'b0;
    end else begin
      case (cmd_i)
        CMD_CLEAR: begin
          clr_q <= clr_q + SLOT_W'(1);
        end
        CMD_HIT: begin
          if (a_split && (tail_q == a_slot)) begin
            tail_q <= ns_slot;
          end
        end
        CMD_APPEND: begin
          used_q <= used_q + HDR_A + need_q;
          tail_q <= slot_of(used_q);
          head_q <= 1'b1;
        end
        CMD_MERGE_A: begin
          if (b_off_q == tail_off) begin
            tail_q <= a_slot;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    status_o.clr_done = (clr_q == LAST_SLOT);
    status_o.a_reach  = head_q && (a_off_q <= tail_off) && (a_off_q < ARENA_A);
    status_o.a_valid  = a_ent_q.valid;
    status_o.a_used   = a_ent_q.used;
    status_o.a_fit    = !a_ent_q.used && (a_ent_q.size >= need_q);
    status_o.a_split  = a_split;
    status_o.b_reach  = head_q && (b_off_q <= tail_off) && (b_off_q < ARENA_A);
    status_o.b_valid  = b_ent_q.valid;
    status_o.b_used   = b_ent_q.used;
    status_o.oom      = (used_q + HDR_A + need_q) > lim_a;
    status_o.free_bad = fbad_q;
    status_o.save_hp  = sv_hp_q;
  end

  assign payload_o = pay_q;

endmodule

// File: hdl/ffha_ctrl.sv
// Sequencer of the allocator: walks, splits, appends and merges via datapath commands.
// Depends on ffha_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ffha_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  op_i,
  input  ffha_pkg::dp_status_t  status_i,
  output ffha_pkg::dp_cmd_e     cmd_o,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [1:0]            res_status_o
);
  import ffha_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_CHK, S_A_EVAL, S_A_APP, S_WR_B, S_B_ADV, S_L_CHK, S_L_EVAL,
    S_M_DONE, S_F_CHK, S_F_EVAL, S_M_SET, S_M_CHK, S_M_EVAL, S_M_KILL, S_P_CHK, S_P_EVAL
  } state_e;

  typedef enum logic [1:0] {K_ALLOC, K_FREE_OWN, K_FREE_PREV} kind_e;

  state_e        state_q, state_d;
  kind_e         kind_q, kind_d;
  logic          done_q, fin;
  alloc_status_e res_q, fin_st;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    cmd_o   = CMD_NONE;
    fin     = 1'b0;
    fin_st  = ST_OK;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_START;
          kind_d  = (op_i == OP_FREE) ? K_FREE_OWN : K_ALLOC;
          state_d = (op_i == OP_FREE) ? S_F_CHK : S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (status_i.a_reach) begin
          cmd_o   = CMD_READ_A;
          state_d = S_A_EVAL;
        end else begin
          state_d = S_A_APP;
        end
      end
      S_A_EVAL: begin
        if (!status_i.a_valid) begin
          state_d = S_A_APP;
        end else if (status_i.a_fit) begin
          cmd_o = CMD_HIT;
          if (status_i.a_split) begin
            state_d = S_WR_B;
          end else begin
            fin     = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          cmd_o   = CMD_STEP_A;
          state_d = S_A_CHK;
        end
      end
      S_A_APP: begin
        fin     = 1'b1;
        state_d = S_IDLE;
        if (status_i.oom) begin
          fin_st = ST_OOM;
        end else begin
          cmd_o = CMD_APPEND;
        end
      end
      S_WR_B: begin
        cmd_o   = CMD_WR_B;
        state_d = S_B_ADV;
      end
      S_B_ADV: begin
        cmd_o   = CMD_B_ADV;
        state_d = S_L_CHK;
      end
      S_L_CHK: begin
        if (status_i.b_reach) begin
          cmd_o   = CMD_READ_B;
          state_d = S_L_EVAL;
        end else begin
          state_d = S_M_DONE;
        end
      end
      S_L_EVAL: begin
        cmd_o   = CMD_LINK_B;
        state_d = S_M_DONE;
      end
      S_M_DONE: begin
        if ((kind_q == K_FREE_OWN) && status_i.save_hp) begin
          cmd_o   = CMD_A_PREV;
          kind_d  = K_FREE_PREV;
          state_d = S_P_CHK;
        end else begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_F_CHK: begin
        if (status_i.free_bad || !status_i.a_reach) begin
          fin     = 1'b1;
          fin_st  = ST_BAD_FREE;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_READ_A;
          state_d = S_F_EVAL;
        end
      end
      S_F_EVAL: begin
        if (!status_i.a_valid || !status_i.a_used) begin
          fin     = 1'b1;
          fin_st  = ST_BAD_FREE;
          state_d = S_IDLE;
        end else begin
          cmd_o   = CMD_FREE_MARK;
          state_d = S_M_SET;
        end
      end
      S_M_SET: begin
        cmd_o   = CMD_B_SET;
        state_d = S_M_CHK;
      end
      S_M_CHK: begin
        if (status_i.b_reach) begin
          cmd_o   = CMD_READ_B;
          state_d = S_M_EVAL;
        end else begin
          state_d = S_M_DONE;
        end
      end
      S_M_EVAL: begin
        if (!status_i.b_valid || status_i.b_used) begin
          state_d = S_M_DONE;
        end else begin
          cmd_o   = CMD_MERGE_A;
          state_d = S_M_KILL;
        end
      end
      S_M_KILL: begin
        cmd_o   = CMD_KILL_B;
        state_d = S_B_ADV;
      end
      S_P_CHK: begin
        if (status_i.a_reach) begin
          cmd_o   = CMD_READ_A;
          state_d = S_P_EVAL;
        end else begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_P_EVAL: begin
        if (!status_i.a_valid || status_i.a_used) begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_M_SET;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      kind_q  <= K_ALLOC;
      done_q  <= 1'b0;
      res_q   <= ST_OK;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      done_q  <= fin;
      if (fin) begin
        res_q <= fin_st;
      end
    end
  end

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign res_status_o = res_q;

  `FFHA_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe lasted more than one cycle")
  `FFHA_ASSERT(a_done_idle, done_q |-> (state_q == S_IDLE), "result shown while still working")
  `FFHA_ASSERT(a_start_busy, (start_i && (state_q == S_IDLE)) |=> busy_o, "item taken but not busy")
  `FFHA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !done_q, "result strobe during reset")

endmodule

// File: hdl/first_fit_heap_allocator_core.sv
// First-fit heap allocator: one item at a time; the header memory is read once for each
// block visited. The result strobe is registered and rises in the cycle after the last step.
// After reset the header memory is cleared, one slot a cycle (all ARENA_BYTES/WORD_BYTES
// slots, 8192 by default), with busy high; the configuration port works throughout.
module first_fit_heap_allocator_core #(
  parameter int unsigned ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned WORD_BYTES   = ffha_pkg::WORD_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffha_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  ffha_pkg::item_t               item_i,
  output logic                          done_o,
  output ffha_pkg::result_t             result_o
);
  import ffha_pkg::*;

  logic [LIMIT_W-1:0] limit_q;
  logic               sel_limit;
  dp_cmd_e            cmd;
  dp_status_t         dp_status;
  logic [PAY_W-1:0]   payload;
  logic [1:0]         res_status;

  assign pready    = 1'b1;
  assign sel_limit = (paddr[PADDR_W-1] == 1'b0);
  assign prdata    = sel_limit ? 32'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && sel_limit) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  ffha_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .op_i         (item_i.op),
    .status_i     (dp_status),
    .cmd_o        (cmd),
    .busy_o       (busy),
    .done_o       (done_o),
    .res_status_o (res_status)
  );

  ffha_dp #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .WORD_BYTES   (WORD_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .item_i    (item_i),
    .limit_i   (limit_q),
    .status_o  (dp_status),
    .payload_o (payload)
  );

  assign result_o.payload_offset = payload;
  assign result_o.status         = res_status;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the first-fit heap allocator core.
// Drives allocate and free items and APB writes of the heap limit, and checks each result
// against an internal model of the arena. Depends on ffha_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int unsigned ARENA = 65536;
  localparam int unsigned HDR   = 32;
  localparam int unsigned WRD   = 8;
  localparam int unsigned SLOTS = ARENA / WRD;
  localparam logic [PADDR_W-1:0] ADDR_LIMIT = '0;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready, start, busy, done_o;
  item_t item_i;
  result_t result_o;

  first_fit_heap_allocator_core DUT (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .item_i, .done_o, .result_o
  );

  bit          blk_valid [SLOTS];
  bit          blk_used  [SLOTS];
  bit          blk_hasprv[SLOTS];
  int unsigned blk_size  [SLOTS];
  int unsigned blk_prev  [SLOTS];
  int unsigned arena_limit;
  bit          heap_nonempty;
  int unsigned last_slot;
  int unsigned arena_used;

  result_t     pending_results[$];
  int unsigned live_offsets[$];
  int          errors = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned slot_at(int unsigned off);
    return (off / WRD < SLOTS) ? off / WRD : SLOTS - 1;
  endfunction

  function automatic bit block_at(int unsigned off);
    return heap_nonempty && off <= last_slot * WRD && off < ARENA && blk_valid[slot_at(off)];
  endfunction

  function automatic void absorb_next(int unsigned off);
    int unsigned s, nb, ns, after;
    s = slot_at(off);
    nb = off + HDR + blk_size[s];
    if (blk_used[s] || !block_at(nb)) return;
    ns = slot_at(nb);
    if (blk_used[ns]) return;
    blk_size[s] += HDR + blk_size[ns];
    if (nb == last_slot * WRD) last_slot = s;
    after = nb + HDR + blk_size[ns];
    if (heap_nonempty && after <= last_slot * WRD && after < ARENA) begin
      blk_prev[slot_at(after)] = s;
      blk_hasprv[slot_at(after)] = 1'b1;
    end
    blk_valid[ns] = 1'b0;
  endfunction

  function automatic result_t predict_alloc(int unsigned req);
    result_t r;
    int unsigned need, lim, off, s, nb, ns, after;
    need = (req == 0) ? 1 : req;
    need = (need + WRD - 1) / WRD * WRD;
    lim = (arena_limit < ARENA) ? arena_limit : ARENA;
    off = 0;
    while (block_at(off)) begin
      s = slot_at(off);
      if (!blk_used[s] && blk_size[s] >= need) begin
        blk_used[s] = 1'b1;
        if (blk_size[s] - need > HDR + 1) begin
          nb = off + HDR + need;
          ns = slot_at(nb);
          blk_valid[ns] = 1'b1;
          blk_used[ns] = 1'b0;
          blk_size[ns] = blk_size[s] - need - HDR;
          blk_prev[ns] = s;
          blk_hasprv[ns] = 1'b1;
          if (last_slot == s) last_slot = ns;
          blk_size[s] = need;
          after = nb + HDR + blk_size[ns];
          if (after <= last_slot * WRD && after < ARENA) begin
            blk_prev[slot_at(after)] = ns;
            blk_hasprv[slot_at(after)] = 1'b1;
          end
        end
        r.payload_offset = 16'(off + HDR);
        r.status = ST_OK;
        return r;
      end
      off += HDR + blk_size[s];
    end
    if (arena_used + HDR + need > lim) begin
      r.payload_offset = '0;
      r.status = ST_OOM;
      return r;
    end
    off = arena_used;
    s = slot_at(off);
    arena_used += HDR + need;
    blk_valid[s] = 1'b1;
    blk_used[s] = 1'b1;
    blk_size[s] = need;
    blk_prev[s] = last_slot;
    blk_hasprv[s] = heap_nonempty;
    last_slot = s;
    heap_nonempty = 1'b1;
    r.payload_offset = 16'(off + HDR);
    r.status = ST_OK;
    return r;
  endfunction

  function automatic result_t predict_free(int unsigned rel);
    result_t r;
    int unsigned off, s, p;
    r.payload_offset = '0;
    if (rel < HDR || (rel - HDR) % WRD != 0 || !block_at(rel - HDR) ||
        !blk_used[slot_at(rel - HDR)]) begin
      r.status = ST_BAD_FREE;
      return r;
    end
    off = rel - HDR;
    s = slot_at(off);
    blk_used[s] = 1'b0;
    absorb_next(off);
    if (blk_hasprv[s]) begin
      p = blk_prev[s] * WRD;
      if (block_at(p)) absorb_next(p);
    end
    r.status = ST_OK;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result offset=%0d status=%0d", $time,
                 result_o.payload_offset, result_o.status);
        errors++;
      end else begin
        result_t e;
        e = pending_results.pop_front();
        if (e.payload_offset !== result_o.payload_offset)
          begin
          $display("%0t: payload_offset expected %0d actual %0d", $time,
                   e.payload_offset, result_o.payload_offset);
          errors++;
        end
        if (e.status !== result_o.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status, result_o.status);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic op, int unsigned req, int unsigned rel);
    item_t it;
    result_t r;
    it.op = op;
    it.request_bytes = 16'(req);
    it.release_offset = 16'(rel);
    @(negedge clk_i);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    r = (op == OP_ALLOC) ? predict_alloc(req) : predict_free(rel);
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_offsets.push_back(r.payload_offset);
    @(negedge clk_i);
    start <= 1'b0;
    item_i <= item_t'($urandom());
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_limit(int unsigned v);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_LIMIT; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    arena_limit = v & 32'h1FFFF;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic free_random_live();
    int unsigned k;
    k = $urandom_range(0, live_offsets.size() - 1);
    send_item(OP_FREE, $urandom(), live_offsets[k]);
    live_offsets.delete(k);
  endtask

  task automatic test_directed();
    send_item(OP_FREE, 0, 32);
    send_item(OP_ALLOC, 0, 16'hFFFF);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 9, 0);
    send_item(OP_ALLOC, 200, 0);
    send_item(OP_ALLOC, 64, 0);
    send_item(OP_FREE, 0, 0);
    send_item(OP_FREE, 0, 33);
    send_item(OP_FREE, 0, 16'hFFFF);
    send_item(OP_FREE, 16'hFFFF, 104);
    send_item(OP_FREE, 0, 104);
    send_item(OP_ALLOC, 40, 0);
    send_item(OP_FREE, 0, 72);
    send_item(OP_FREE, 0, 72);
    send_item(OP_FREE, 0, 32);
    send_item(OP_FREE, 0, 48);
    send_item(OP_ALLOC, 16'hFFFF, 0);
    send_item(OP_ALLOC, 16, 0);
    drain();
    live_offsets.delete();
    for (int i = 0; i < SLOTS; i++) if (blk_valid[i] && blk_used[i])
      live_offsets.push_back(i * WRD + HDR);
  endtask

  task automatic test_limits();
    write_limit(0);
    send_item(OP_ALLOC, 8, 0);
    drain();
    write_limit(32'h1FFFF);
    send_item(OP_ALLOC, 16'hFFFF, 0);
    drain();
    write_limit(arena_used + 100);
    send_item(OP_ALLOC, 60, 0);
    send_item(OP_ALLOC, 8, 0);
    drain();
  endtask

  task automatic test_random(int unsigned count, int unsigned limit_val);
    int unsigned sel;
    write_limit(limit_val);
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) send_item(OP_ALLOC, ($urandom_range(0, 15) == 0) ?
                              $urandom_range(0, 65535) : $urandom_range(0, 300), $urandom());
      else if (sel < 85 && live_offsets.size() != 0) free_random_live();
      else if (sel < 92) send_item(OP_FREE, $urandom(), $urandom_range(0, 65535));
      else send_item(OP_FREE, $urandom(), $urandom_range(0, 8191) * 8);
      if (i == count / 2) drain();
      else if ($urandom_range(0, 2) == 0) idle_gap();
    end
    drain();
  endtask

  initial begin
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; item_i = '0;
    arena_limit = LIMIT_RESET;
    heap_nonempty = 1'b0; last_slot = 0; arena_used = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_limits();
    test_random(220, 32'h10000);
    test_random(220, 32'h1FFFF);
    test_random(200, 65535);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// File: first_fit_heap_allocator_core.f
+incdir+hdl
hdl/ffha_pkg.sv
hdl/ffha_dp.sv
hdl/ffha_ctrl.sv
hdl/first_fit_heap_allocator_core.sv
test/testbench.sv
